FILE: rtl/sri_pkg.sv
// Shared types and constants for the segment/quadrilateral intersection pipeline.
// No dependencies.
package sri_pkg;
	localparam int CW  = 32;          // coordinate width
	localparam int DW  = CW + 1;      // difference width
	localparam int PW  = 2 * DW;      // product width
	localparam int XW  = PW + 1;      // cross product width
	localparam int TW  = 17;          // Q1.16 result width
	localparam int QB  = 16;          // fraction bits
	localparam int NE  = 4;           // edges

	typedef logic signed [DW-1:0] diff_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [XW-1:0] cross_t;
	typedef logic [XW-1:0] mag_t;
	typedef logic [TW-1:0] tq_t;

	typedef struct packed {
		logic ok;
		mag_t den;
		mag_t rem;
		tq_t  q;
	} div_t;
endpackage

FILE: rtl/sri_edge_div.sv
// Restoring divider for one edge: one quotient bit per pipeline stage.
// Depends on sri_pkg.
module sri_edge_div import sri_pkg::*; (
	input  logic clk,
	input  logic en,
	input  div_t din,
	output div_t dout
);
	div_t st_s [0:QB];
	div_t pv [0:QB];
	div_t nx [0:QB];

	always_comb begin
		pv[0] = din;
		for (int k = 1; k <= QB; k++) pv[k] = st_s[k-1];
	end

	always_comb begin
		for (int k = 0; k <= QB; k++) begin
			mag_t r;
			div_t p;
			p = pv[k];
			r = (k == 0) ? p.rem : {p.rem[XW-2:0], 1'b0};
			nx[k] = p;
			if (r >= p.den) begin
				nx[k].rem = r - p.den;
				nx[k].q = {p.q[TW-2:0], 1'b1};
			end else begin
				nx[k].rem = r;
				nx[k].q = {p.q[TW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k <= QB; k++) st_s[k] <= nx[k];
		end
	end

	assign dout = st_s[QB];
endmodule

FILE: rtl/segment_rectangle_intersection.sv
// Segment versus quadrilateral intersection, top level.
// Pipeline: differences, products, cross/normalise, 17 divide stages, min.
// Throughput one word per cycle; a stalled output holds the whole pipeline.
// arst_n clears the valid bits only; payload registers are not reset.
// Depends on sri_pkg and sri_edge_div.
module segment_rectangle_intersection import sri_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// seg_start_x, seg_start_y, seg_end_x, seg_end_y, vertex0_x .. vertex3_y
	input  logic [12*CW-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// hit, nearest_t, 6 bits zero pad
	output logic [23:0] m_tdata
);
	localparam int NS = 4 + QB;
	logic [NS:0] v_q;
	logic en;
	assign en = m_tready || !m_tvalid;
	assign s_tready = en;

	logic signed [CW-1:0] f [12];
	always_comb for (int i = 0; i < 12; i++) f[i] = s_tdata[i*CW +: CW];

	diff_t dx_s1, dy_s1;
	diff_t ex_s1 [NE], ey_s1 [NE], wx_s1 [NE], wy_s1 [NE];
	prod_t p_s2 [NE][6];
	div_t d_s3 [NE];
	div_t dq [NE];
	logic hit_s4;
	tq_t t_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DW'(f[2]) - DW'(f[0]);
			dy_s1 <= DW'(f[3]) - DW'(f[1]);
			for (int i = 0; i < NE; i++) begin
				ex_s1[i] <= DW'(f[4+2*((i+1)%NE)]) - DW'(f[4+2*i]);
				ey_s1[i] <= DW'(f[5+2*((i+1)%NE)]) - DW'(f[5+2*i]);
				wx_s1[i] <= DW'(f[0]) - DW'(f[4+2*i]);
				wy_s1[i] <= DW'(f[1]) - DW'(f[5+2*i]);
			end
			for (int i = 0; i < NE; i++) begin
				p_s2[i][0] <= dx_s1 * ey_s1[i];
				p_s2[i][1] <= ex_s1[i] * dy_s1;
				p_s2[i][2] <= dx_s1 * wy_s1[i];
				p_s2[i][3] <= dy_s1 * wx_s1[i];
				p_s2[i][4] <= ex_s1[i] * wy_s1[i];
				p_s2[i][5] <= ey_s1[i] * wx_s1[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NE; i++) begin
				cross_t dn, sn, tn;
				dn = XW'(p_s2[i][0]) - XW'(p_s2[i][1]);
				sn = XW'(p_s2[i][2]) - XW'(p_s2[i][3]);
				tn = XW'(p_s2[i][4]) - XW'(p_s2[i][5]);
				if (dn < 0) begin
					dn = -dn;
					sn = -sn;
					tn = -tn;
				end
				d_s3[i].ok <= (dn != 0) && (sn >= 0) && (sn <= dn) && (tn >= 0) && (tn <= dn);
				d_s3[i].den <= mag_t'(dn);
				d_s3[i].rem <= mag_t'(tn);
				d_s3[i].q <= '0;
			end
		end
	end

	for (genvar g = 0; g < NE; g++) begin : g_div
		sri_edge_div u_div (.clk, .en, .din(d_s3[g]), .dout(dq[g]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			logic any;
			tq_t best;
			any = 1'b0;
			best = '0;
			for (int i = 0; i < NE; i++) begin
				if (dq[i].ok && (!any || dq[i].q < best)) best = dq[i].q;
				if (dq[i].ok) any = 1'b1;
			end
			hit_s4 <= any;
			t_s4 <= best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NS-1:0], s_tvalid};
		end
	end

	assign m_tvalid = v_q[NS];
	assign m_tdata = {6'd0, t_s4, hit_s4};

`ifndef NO_ASSERTIONS
	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[17:1] == '0) else $error("t without hit");
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[17:1] <= tq_t'(1 << QB)) else $error("t above one");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output lost");
`endif
endmodule

FILE: bench/tb_segment_rectangle_intersection.sv
// Testbench for segment_rectangle_intersection: a segment against four polygon edges.
// Directed table then random geometry, checked by the table or a local predictor.
// Depends on sri_pkg and the RTL of the block.
module tb_segment_rectangle_intersection import sri_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] c [12];
		logic        chk;
		logic        hit;
		logic [16:0] t;
	} row_t;

	typedef struct {
		logic        hit;
		logic [16:0] t;
	} isect_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [12*CW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [23:0] m_tdata;

	isect_t pending[$];
	int errors = 0;
	int n_sent = 0;
	bit sending = 1;
	int hold_at = 900;

	segment_rectangle_intersection dut (.*);

	always #10 clk = ~clk;

	function automatic logic [16:0] div_q(logic [127:0] num, logic [127:0] den);
		logic [127:0] r;
		logic [16:0] q;
		r = num;
		q = '0;
		if (r >= den) begin
			q = 17'd1;
			r = r - den;
		end
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic isect_t nearest_hit(logic [31:0] c [12]);
		logic signed [127:0] px, py, dx, dy, ax, ay, ex, ey, wx, wy, den, sn, tn;
		isect_t r;
		logic [16:0] t;
		int j;
		r.hit = 0;
		r.t = '0;
		px = $signed(c[0]);
		py = $signed(c[1]);
		dx = $signed(c[2]) - px;
		dy = $signed(c[3]) - py;
		for (int i = 0; i < 4; i++) begin
			j = (i + 1) % 4;
			ax = $signed(c[4+2*i]);
			ay = $signed(c[5+2*i]);
			ex = $signed(c[4+2*j]) - ax;
			ey = $signed(c[5+2*j]) - ay;
			wx = px - ax;
			wy = py - ay;
			den = dx * ey - ex * dy;
			sn = dx * wy - dy * wx;
			tn = ex * wy - ey * wx;
			if (den == 0) continue;
			if (den < 0) begin
				den = -den;
				sn = -sn;
				tn = -tn;
			end
			if (sn < 0 || sn > den || tn < 0 || tn > den) continue;
			t = div_q(tn, den);
			if (!r.hit || t < r.t) r.t = t;
			r.hit = 1;
		end
		return r;
	endfunction

	function automatic logic [31:0] rcoord(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 40)) - 20) << 16;
			2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
			default: return 32'($signed($urandom_range(0, 2000)) - 1000) << 12;
		endcase
	endfunction

	task automatic send(logic [31:0] c [12], logic chk, logic hit, logic [16:0] t);
		isect_t e;
		while ($urandom_range(0, 99) < 24 && !(n_sent > 1000 && n_sent < 1400)) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		for (int i = 0; i < 12; i++) s_tdata[32*i +: 32] <= c[i];
		s_tvalid <= 1;
		e = nearest_hit(c);
		if (chk) begin
			e.hit = hit;
			e.t = t;
		end
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending.push_back(e);
		n_sent++;
	endtask

	// sink: random backpressure, one long hold-off, no stalls in a middle stretch
	always @(posedge clk) begin
		isect_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word %h", m_tdata);
			end else begin
				e = pending.pop_front();
				if (m_tdata[0] !== e.hit || m_tdata[17:1] !== e.t || m_tdata[23:18] !== 0) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp hit=%b t=%h got hit=%b t=%h",
							e.hit, e.t, m_tdata[0], m_tdata[17:1]);
				end
			end
		end
		if (hold_at > 0 && n_sent >= hold_at) begin
			hold_at = -200;
			m_tready <= 0;
		end else if (hold_at < 0) begin
			hold_at++;
			m_tready <= 0;
		end else if (n_sent > 1000 && n_sent < 1400)
			m_tready <= 1;
		else
			m_tready <= ($urandom_range(0, 99) >= 24);
	end

	initial begin
		#50ms;
		$display("tb_segment_rectangle_intersection: done, errors");
		$finish;
	end

	initial begin
		row_t tbl[$];
		row_t r;
		logic [31:0] c [12];
		int mode, w;
		logic [31:0] sq [8];
		sq = '{32'h0, 32'h0, 32'h0004_0000, 32'h0, 32'h0004_0000, 32'h0004_0000,
			32'h0, 32'h0004_0000};
		// crossing through square, expect t=0.25
		r.c = '{32'hffff_0000, 32'h0002_0000, 32'h0003_0000, 32'h0002_0000,
			sq[0], sq[1], sq[2], sq[3], sq[4], sq[5], sq[6], sq[7]};
		r.chk = 1; r.hit = 1; r.t = 17'h04000; tbl.push_back(r);
		// zero-length segment
		r.c[2] = 32'hffff_0000; r.c[3] = 32'h0002_0000; r.hit = 0; r.t = 0; tbl.push_back(r);
		// segment collinear with bottom edge: parallel, but crosses sides at ends
		r.c = '{32'hffff_0000, 32'h0, 32'h0005_0000, 32'h0,
			sq[0], sq[1], sq[2], sq[3], sq[4], sq[5], sq[6], sq[7]};
		r.chk = 0; tbl.push_back(r);
		// touching at end point, t=1
		r.c = '{32'hfffe_0000, 32'h0002_0000, 32'h0, 32'h0002_0000,
			sq[0], sq[1], sq[2], sq[3], sq[4], sq[5], sq[6], sq[7]};
		r.chk = 1; r.hit = 1; r.t = 17'h10000; tbl.push_back(r);
		// miss entirely
		r.c[0] = 32'h000a_0000; r.c[2] = 32'h000b_0000; r.hit = 0; r.t = 0; tbl.push_back(r);
		// degenerate polygon, all vertices equal
		for (int i = 4; i < 12; i++) r.c[i] = 32'h0001_0000;
		tbl.push_back(r);
		// extremes of the coordinate range
		for (int k = 0; k < 6; k++) begin
			for (int i = 0; i < 12; i++)
				r.c[i] = (((k + i) % 3) == 0) ? 32'h8000_0000 :
					(((k + i) % 3) == 1) ? 32'h7fff_ffff : 32'h0;
			r.chk = 0; tbl.push_back(r);
		end
		r.c = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		r.chk = 0; tbl.push_back(r);
		for (int i = 0; i < 12; i++) r.c[i] = 32'hffff_ffff;
		tbl.push_back(r);

		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (tbl[k]) send(tbl[k].c, tbl[k].chk, tbl[k].hit, tbl[k].t);
		for (int n = 0; n < 1940; n++) begin
			mode = $urandom_range(0, 3);
			for (int i = 0; i < 12; i++) c[i] = rcoord(mode);
			if (mode == 3 && $urandom_range(0, 1)) begin
				// axis-aligned square, segment endpoints drawn at random from the same coordinate range
				w = $urandom_range(1, 200);
				c[4] = rcoord(3); c[5] = rcoord(3);
				c[6] = c[4] + (w << 12); c[7] = c[5];
				c[8] = c[6]; c[9] = c[5] + (w << 12);
				c[10] = c[4]; c[11] = c[9];
			end
			send(c, 0, 0, 0);
		end
		s_tvalid <= 0;
		while (pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb_segment_rectangle_intersection: done, clean");
		else
			$display("tb_segment_rectangle_intersection: done, errors");
		$finish;
	end
endmodule
